// ===== rtl/alrt_pkg.sv =====
// Package for the address range lookup table: request and result payloads,
// the record handed along the cell chain, the commit broadcast and op codes.
// No dependencies.
package alrt_pkg;

    localparam logic       OP_NOTE      = 1'b0;
    localparam logic       OP_FIND      = 1'b1;
    localparam logic [1:0] HEAP_DEFAULT = 2'd0;

    typedef struct packed {
        logic        operation;
        logic [63:0] address;
        logic [63:0] length;
        logic [63:0] handle;
        logic        is_buffer;
        logic        reserved;
        logic        heap_query_ok;
        logic [1:0]  heap_kind;
    } alrt_req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] found_handle;
        logic [63:0] offset;
        logic [1:0]  found_heap;
        logic [6:0]  entry_count;
        logic        table_full;
    } alrt_rsp_t;

    // Travels one cell per cycle while a request walks the table.
    typedef struct packed {
        logic        tok;
        logic [63:0] addr;
        logic        best_v;
        logic [63:0] best_start;
        logic [63:0] best_len;
        logic [63:0] best_handle;
        logic [1:0]  best_heap;
        logic        match_found;
        logic        free_found;
    } alrt_rec_t;

    // Broadcast to every cell at the end of a note walk.
    typedef struct packed {
        logic        en;
        logic        any_match;
        logic [63:0] start;
        logic [63:0] length;
        logic [63:0] handle;
        logic [1:0]  heap;
    } alrt_commit_t;

endpackage

// ===== rtl/alrt_cell.sv =====
// One table entry of the address range lookup table, with its stage of the
// request chain. Depends on alrt_pkg.
module alrt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  alrt_pkg::alrt_rec_t   rec_i,
    output alrt_pkg::alrt_rec_t   rec_o,
    input  alrt_pkg::alrt_commit_t commit_i
);
    import alrt_pkg::*;

    logic        valid_reg;
    logic [63:0] start_reg;
    logic [63:0] len_reg;
    logic [63:0] handle_reg;
    logic [1:0]  heap_reg;
    logic        match_reg;
    logic        first_free_reg;
    alrt_rec_t   rec_reg;
    alrt_rec_t   rec_next;

    logic same_start;
    logic take;
    logic wr;

    assign same_start = valid_reg && (start_reg == rec_i.addr);
    assign take = valid_reg && (start_reg <= rec_i.addr) &&
                  (!rec_i.best_v || (start_reg > rec_i.best_start));
    assign wr = commit_i.en && (commit_i.any_match ? match_reg : first_free_reg);

    always_comb begin
        rec_next             = rec_i;
        rec_next.match_found = rec_i.match_found || same_start;
        rec_next.free_found  = rec_i.free_found || !valid_reg;
        if (take) begin
            rec_next.best_v      = 1'b1;
            rec_next.best_start  = start_reg;
            rec_next.best_len    = len_reg;
            rec_next.best_handle = handle_reg;
            rec_next.best_heap   = heap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            rec_reg.tok <= 1'b0;
        end else begin
            rec_reg <= rec_next;
            if (wr) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // Latch this cell's role for the commit that ends the walk.
        if (rec_i.tok) begin
            match_reg      <= same_start;
            first_free_reg <= !valid_reg && !rec_i.free_found;
        end
        if (wr) begin
            start_reg  <= commit_i.start;
            len_reg    <= commit_i.length;
            handle_reg <= commit_i.handle;
            heap_reg   <= commit_i.heap;
        end
    end

    assign rec_o = rec_reg;

endmodule

// ===== rtl/address_range_lookup_table.sv =====
// Address range lookup table: top level, a chain of CAPACITY entry cells.
// Depends on alrt_pkg and alrt_cell.
//
// Usage: requests arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, exactly one result per request. A note request
// stores a buffer range (start, length, handle, heap), replacing the entry
// with the same start; a find request returns the range with the greatest
// start not above the address, if the address lies inside it.
// Each request walks the cell chain one cell per cycle, and a new request
// is taken only once the previous one has left the chain.
// The walk length is set by the chain depth: one cell compares per cycle.
// At the end of a note walk the chosen cell is written by broadcast.
// Reset (aresetn low, synchronous) clears all entry valid bits and the
// count at once; there is no clearing pass.
// When the receiver stalls, the finished result waits in the output
// register and the next request is still taken; a further result is held
// in a side register until the output register frees.
module address_range_lookup_table #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  alrt_pkg::alrt_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output alrt_pkg::alrt_rsp_t m_data
);
    import alrt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t       state_reg, state_next;
    alrt_req_t    req_reg;
    alrt_req_t    req_in;
    logic [CNT_W-1:0] count_reg, count_next;
    logic         m_valid_reg, m_valid_next;
    alrt_rsp_t    m_data_reg, m_data_next;
    alrt_rsp_t    res_reg, res_next;

    alrt_rec_t    chain [CAPACITY+1];
    alrt_rec_t    chain_head;
    alrt_rec_t    chain_out;
    alrt_commit_t commit;

    logic         accept;
    logic         walk_end;
    logic         note_eff;
    logic [63:0]  off;
    logic [31:0]  cnt_ext;
    alrt_rsp_t    res;
    logic [1:0]   heap_eff;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Force the default heap for reserved resources or a failed query.
    assign heap_eff = (s_data.reserved || !s_data.heap_query_ok) ?
                      HEAP_DEFAULT : s_data.heap_kind;

    always_comb begin
        req_in           = s_data;
        req_in.heap_kind = heap_eff;
    end

    // Inject the request into the head of the chain on acceptance.
    always_comb begin
        chain_head      = '0;
        chain_head.tok  = accept;
        chain_head.addr = s_data.address;
    end

    assign chain[0] = chain_head;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        alrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .rec_i    (chain[i]),
            .rec_o    (chain[i+1]),
            .commit_i (commit)
        );
    end

    assign chain_out = chain[CAPACITY];
    assign walk_end  = (state_reg == ST_WALK) && chain_out.tok;

    // Zero starts and non-buffers are dropped without touching the table.
    assign note_eff = (req_reg.operation == OP_NOTE) && req_reg.is_buffer &&
                      (req_reg.address != 64'd0);

    // Write the matching cell if the start is known, else the first free one.
    always_comb begin
        commit.en        = walk_end && note_eff &&
                           (chain_out.match_found || chain_out.free_found);
        commit.any_match = chain_out.match_found;
        commit.start     = req_reg.address;
        commit.length    = req_reg.length;
        commit.handle    = req_reg.handle;
        commit.heap      = req_reg.heap_kind;
    end

    always_comb begin
        count_next = count_reg;
        if (commit.en && !chain_out.match_found) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign cnt_ext = 32'(count_next);
    assign off     = req_reg.address - chain_out.best_start;

    always_comb begin
        res             = '0;
        res.entry_count = cnt_ext[6:0];
        if (req_reg.operation == OP_NOTE) begin
            res.table_full = note_eff && !chain_out.match_found &&
                             !chain_out.free_found;
        end else if (chain_out.best_v && (req_reg.address != 64'd0) &&
                     (off < chain_out.best_len)) begin
            res.hit          = 1'b1;
            res.found_handle = chain_out.best_handle;
            res.offset       = off;
            res.found_heap   = chain_out.best_heap;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (chain_out.tok) begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_next  = res;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        res_next   = res;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (walk_end) begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the request for the commit and the result at the end of the walk.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        if (accept) begin
            req_reg <= req_in;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_tok_in_walk : assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.tok |-> (state_reg == ST_WALK))
        else $error("request left the chain outside a walk");

    a_accept_walk : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_WALK))
        else $error("accepted request did not start a walk");

    a_count_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("entry count above capacity");

    a_hit_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.hit && m_data.table_full))
        else $error("result flags both hit and table full");

endmodule

// ===== sim/alrt_checker.sv =====
// Checker for the address range lookup table: watches both channels, keeps its
// own copy of the range table and compares every result with its prediction.
// Depends on alrt_pkg.
module alrt_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  alrt_pkg::alrt_req_t s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  alrt_pkg::alrt_rsp_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  hits_seen,
    output int                  drops_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import alrt_pkg::*;

    logic [63:0] tbl_start  [CAPACITY];
    logic [63:0] tbl_len    [CAPACITY];
    logic [63:0] tbl_handle [CAPACITY];
    logic [1:0]  tbl_heap   [CAPACITY];
    logic        tbl_valid  [CAPACITY];
    logic [12:0] tbl_count;

    alrt_rsp_t   awaited_results [$];
    int          errs  = 0;
    int          hits  = 0;
    int          drops = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
        hits_seen  = 0;
        drops_seen = 0;
    end

    // Apply one request to the table copy and return the result it must give.
    function automatic alrt_rsp_t range_table_step(input alrt_req_t r);
        alrt_rsp_t   rsp;
        int          slot;
        int          free_slot;
        int          best;
        logic [1:0]  heap;
        logic [64:0] range_end;
        rsp       = '0;
        slot      = -1;
        free_slot = -1;
        best      = -1;
        if (r.operation == OP_NOTE) begin
            if (r.is_buffer && r.address != '0) begin
                heap = (r.reserved || !r.heap_query_ok) ? HEAP_DEFAULT : r.heap_kind;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_valid[i]) begin
                        if (slot < 0 && tbl_start[i] == r.address)
                            slot = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (slot < 0 && free_slot >= 0) begin
                    slot             = free_slot;
                    tbl_valid[slot]  = 1'b1;
                    tbl_count        = tbl_count + 1;
                end
                if (slot >= 0) begin
                    tbl_start[slot]  = r.address;
                    tbl_len[slot]    = r.length;
                    tbl_handle[slot] = r.handle;
                    tbl_heap[slot]   = heap;
                end else begin
                    rsp.table_full = 1'b1;
                end
            end
        end else if (r.address != '0) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (tbl_valid[i] && tbl_start[i] <= r.address &&
                    (best < 0 || tbl_start[i] > tbl_start[best]))
                    best = i;
            end
            if (best >= 0) begin
                // range end is one bit wider so that it never wraps
                range_end = {1'b0, tbl_start[best]} + {1'b0, tbl_len[best]};
                if ({1'b0, r.address} < range_end) begin
                    rsp.hit          = 1'b1;
                    rsp.found_handle = tbl_handle[best];
                    rsp.offset       = r.address - tbl_start[best];
                    rsp.found_heap   = tbl_heap[best];
                end
            end
        end
        rsp.entry_count = tbl_count[6:0];
        return rsp;
    endfunction

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            if (errs < 10)
                $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        alrt_rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++)
                tbl_valid[i] = 1'b0;
            tbl_count = '0;
            awaited_results.delete();
        end else begin
            // results first: a request taken at this edge cannot have produced one yet
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    if (errs < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    errs++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("hit",          64'(want.hit),         64'(m_data.hit));
                    check_field("found_handle", want.found_handle,     m_data.found_handle);
                    check_field("offset",       want.offset,           m_data.offset);
                    check_field("found_heap",   64'(want.found_heap),  64'(m_data.found_heap));
                    check_field("entry_count",  64'(want.entry_count), 64'(m_data.entry_count));
                    check_field("table_full",   64'(want.table_full),  64'(m_data.table_full));
                    if (m_data.hit)
                        hits++;
                    if (m_data.table_full)
                        drops++;
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(range_table_step(s_data));
        end
        fail_count <= errs;
        pending    <= awaited_results.size();
        hits_seen  <= hits;
        drops_seen <= drops;
    end

endmodule

// ===== sim/tb.sv =====
// Top of the address range lookup table testbench: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on alrt_pkg, address_range_lookup_table and alrt_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import alrt_pkg::*;

    localparam int CAP      = 64;
    localparam int POOL     = 80;       // more starts than slots, so the table fills
    localparam int ROOMY    = 48;       // starts used while the table must keep room
    localparam int PHASE1   = 580;
    localparam int PHASE2   = 400;
    localparam int HOLD_OFF = 600;      // long receiver stall, in cycles
    localparam int LIMIT    = 400000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    alrt_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    alrt_rsp_t m_data;

    int fail_count;
    int pending;
    int hits_seen;
    int drops_seen;

    int          cycles        = 0;
    int          notes_sent    = 0;
    int          finds_sent    = 0;
    int          results_taken = 0;
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    logic [63:0] start_pool [POOL];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    address_range_lookup_table #(.CAPACITY(CAP)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    alrt_checker #(.CAPACITY(CAP)) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .hits_seen  (hits_seen),
        .drops_seen (drops_seen)
    );

    // Abort a hung run: no correct run comes anywhere near this many cycles.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic alrt_req_t note_req(input logic [63:0] addr, input logic [63:0] len,
                                           input logic [63:0] handle, input logic [1:0] heap,
                                           input logic is_buf, input logic resv,
                                           input logic qok);
        alrt_req_t r;
        r.operation     = OP_NOTE;
        r.address       = addr;
        r.length        = len;
        r.handle        = handle;
        r.is_buffer     = is_buf;
        r.reserved      = resv;
        r.heap_query_ok = qok;
        r.heap_kind     = heap;
        return r;
    endfunction

    // Fill the fields a find does not use with junk; the block must ignore them.
    function automatic alrt_req_t find_req(input logic [63:0] addr);
        alrt_req_t r;
        r           = note_req(addr, rand64(), rand64(), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
        r.operation = OP_FIND;
        return r;
    endfunction

    function automatic logic [63:0] random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 18)
            return rand64();
        if (pick < 24)
            return '1;
        return 64'($urandom_range(1, 'h1000));
    endfunction

    // Aim most finds just around known starts so that hits, misses past the
    // end and shadowing by a neighbour all turn up.
    function automatic logic [63:0] random_find_address(input int pool_used);
        int          pick;
        logic [63:0] base;
        pick = $urandom_range(0, 99);
        base = start_pool[$urandom_range(0, pool_used - 1)];
        if (pick < 5)
            return '0;
        if (pick < 12)
            return rand64();
        if (pick < 16)
            return '1;
        if (pick < 22)
            return base - 1;
        return base + 64'($urandom_range(0, 'h1800));
    endfunction

    function automatic alrt_req_t random_request(input int pool_used, input bit keep_room);
        alrt_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r = note_req(start_pool[$urandom_range(0, pool_used - 1)], random_length(),
                         ($urandom_range(0, 19) == 0) ? 64'd0 : rand64(),
                         2'($urandom_range(0, 3)), 1'b1, $urandom_range(0, 4) == 0,
                         $urandom_range(0, 4) != 0);
        end else if (pick < 52) begin
            // stray note at a random start; keep it a non-buffer while room matters
            r = note_req(rand64(), rand64(), rand64(), 2'($urandom_range(0, 3)),
                         keep_room ? 1'b0 : 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            r = find_req(random_find_address(pool_used));
        end
        return r;
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input alrt_req_t r);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (r.operation == OP_NOTE)
            notes_sent++;
        else
            finds_sent++;
    endtask

    // Drop valid and wait for every outstanding result. Step past the current
    // edge first so that the request just taken is already counted.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // Result side: a random stall per result, calm stretches without any, and
    // one long hold-off so that the block fills up and refuses requests.
    initial begin
        int w;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
            if (results_taken == 150)
                w = HOLD_OFF;
            else
                w = receiver_calm ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            results_taken++;
        end
    end

    initial begin
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;

        // Starts: overlapping clusters, a group just below the top of the
        // address space, and scattered values for the upper bits.
        for (int i = 0; i < POOL; i++) begin
            if (i < 24)
                start_pool[i] = 64'h0000_0000_1000_0000 + i * 'h800 + $urandom_range(0, 'h3ff);
            else if (i < 32)
                start_pool[i] = 64'hFFFF_FFFF_FFFF_0000 + (i - 24) * 'h400 +
                                $urandom_range(0, 'hff);
            else
                start_pool[i] = rand64() | 64'h1;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, ignored notes, replacement, heap override.
        send_request(find_req('0));
        send_request(find_req('1));
        send_request(note_req(64'h1000, 64'h100, '1, 2'd1, 1'b0, 1'b0, 1'b1));
        send_request(note_req('0, 64'h100, 64'h5, 2'd2, 1'b1, 1'b0, 1'b1));
        send_request(note_req(64'h1000, 64'h100, '0, 2'd2, 1'b1, 1'b0, 1'b1));
        send_request(note_req(64'h1000, 64'h2000, 64'hDEAD_BEEF_0000_0001, 2'd3,
                              1'b1, 1'b1, 1'b1));
        // zero-length range sitting inside the one above it, failed heap query
        send_request(note_req(64'h2000, '0, 64'h22, 2'd1, 1'b1, 1'b0, 1'b0));
        // range whose end lies past the top of the address space
        send_request(note_req(64'hFFFF_FFFF_FFFF_FF00, '1, 64'h33, 2'd3, 1'b1, 1'b0, 1'b1));
        send_request(note_req(64'h1, 64'h1, 64'h44, 2'd1, 1'b1, 1'b0, 1'b1));
        send_request(find_req(64'h1000));
        send_request(find_req(64'h1FFF));
        send_request(find_req(64'h2000));
        send_request(find_req(64'h2800));
        send_request(find_req('1));
        send_request(find_req(64'hFFFF_FFFF_FFFF_FF00));
        send_request(find_req(64'hFFFF_FFFF_FFFF_FEFF));
        send_request(find_req(64'h1));
        send_request(find_req(64'h2));
        send_request(note_req(64'h1000, 64'h10, 64'h55, 2'd2, 1'b1, 1'b0, 1'b1));
        send_request(find_req(64'h100F));
        send_request(find_req(64'h1010));
        send_request(note_req(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '1, 2'd3,
                              1'b1, 1'b0, 1'b1));
        send_request(find_req('1));

        // Random, table kept below capacity.
        for (int i = 0; i < PHASE1; i++) begin
            if (i % 50 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_request(random_request(ROOMY, 1'b1));
        end

        // Pause until the block is empty, then let the table fill and overflow.
        drain_results();
        for (int i = 0; i < PHASE2; i++) begin
            if (i % 50 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_request(random_request(POOL, 1'b0));
        end

        drain_results();
        repeat (CAP + 10) @(posedge aclk);

        $display("Sent %0d requests: %0d notes, %0d finds, across a fill past capacity.",
                 notes_sent + finds_sent, notes_sent, finds_sent);
        $display("Results seen: %0d hits, %0d dropped notes, %0d mismatches.",
                 hits_seen, drops_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/alrt_pkg.sv
rtl/alrt_cell.sv
rtl/address_range_lookup_table.sv
sim/alrt_checker.sv
sim/tb.sv
